// ===== hdl/hcs_pkg.sv =====
// Package for the heater channel supervisor: beat payloads, state, register codes.
// No dependencies; every other file of the block imports it.
`default_nettype none

package hcs_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [9:0] DUTY_MAX = 10'd1000;
   localparam logic [9:0] MS_PER_S = 10'd1000;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_ACTIVE = 2'd1,
      MODE_SLEEP  = 2'd2,
      MODE_ERROR  = 2'd3
   } hcs_mode_type;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_TOGGLE = 3'd1,
      CMD_SET    = 3'd2,
      CMD_STEP   = 3'd3,
      CMD_FORCE  = 3'd4
   } hcs_cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_TARGET     = 3'd0,
      CSR_MAX_TARGET     = 3'd1,
      CSR_SLEEP_TARGET   = 3'd2,
      CSR_SLEEP_TIMEOUT  = 3'd3,
      CSR_WATCH_DUTY_THR = 3'd4,
      CSR_WATCH_TIMEOUT  = 3'd5,
      CSR_WATCH_MIN_RISE = 3'd6
   } hcs_csr_type;

   typedef struct packed {
      logic        [2:0]  command;
      logic signed [15:0] value;
      logic        [1:0]  forced_state;
      logic signed [15:0] measured_temp;
      logic        [9:0]  pid_duty;
      logic        [15:0] tick_ms;
   } hcs_req_type;

   typedef struct packed {
      logic        [9:0]  duty_out;
      hcs_mode_type       channel_state;
      logic signed [15:0] active_target;
      logic signed [15:0] user_target;
      logic               pid_clear;
      logic               runaway_fault;
   } hcs_rsp_type;

   typedef struct packed {
      logic signed [15:0] min_target;
      logic signed [15:0] max_target;
      logic signed [15:0] sleep_target;
      logic        [15:0] sleep_timeout_s;
      logic        [9:0]  watch_duty_threshold;
      logic        [31:0] watch_timeout_ms;
      logic signed [15:0] watch_min_rise;
   } hcs_cfg_type;

   typedef struct packed {
      hcs_mode_type       mode;
      logic signed [15:0] target_temp;
      logic        [31:0] idle_ms;
      logic        [31:0] watch_ms;
      logic signed [15:0] checkpoint_temp;
      logic        [9:0]  last_duty;
   } hcs_state_type;

   localparam hcs_cfg_type CFG_RESET = '{
      min_target:           16'sd0,
      max_target:           16'sd450,
      sleep_target:         16'sd150,
      sleep_timeout_s:      16'd0,
      watch_duty_threshold: 10'd800,
      watch_timeout_ms:     32'd20000,
      watch_min_rise:       16'sd5
   };

   localparam hcs_state_type STATE_RESET = '{
      mode:            MODE_OFF,
      target_temp:     16'sd0,
      idle_ms:         32'd0,
      watch_ms:        32'd0,
      checkpoint_temp: 16'sd0,
      last_duty:       10'd0
   };

endpackage

`default_nettype wire

// ===== hdl/hcs_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on hcs_pkg for the payload types.
`default_nettype none

interface hcs_req_if;
   import hcs_pkg::*;
   logic        valid;
   logic        ready;
   hcs_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hcs_rsp_if;
   import hcs_pkg::*;
   logic        valid;
   logic        ready;
   hcs_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/hcs_step.sv =====
// Combinational step of the supervisor: next channel state and response beat.
// Depends on hcs_pkg.
`default_nettype none

module hcs_step (
   input  hcs_pkg::hcs_state_type state_cur,
   input  hcs_pkg::hcs_cfg_type   cfg,
   input  hcs_pkg::hcs_req_type   item,
   output hcs_pkg::hcs_state_type state_nxt,
   output hcs_pkg::hcs_rsp_type   result
);
   import hcs_pkg::*;

   function automatic logic signed [15:0] clamp_target(
      input logic signed [16:0] t,
      input logic signed [15:0] lo,
      input logic signed [15:0] hi
   );
      logic signed [16:0] lo_x;
      logic signed [16:0] hi_x;
      logic signed [16:0] r;
      lo_x = $signed({lo[15], lo});
      hi_x = $signed({hi[15], hi});
      r    = (t < lo_x) ? lo_x : t;
      r    = (r > hi_x) ? hi_x : r;
      return r[15:0];
   endfunction

   hcs_cmd_type        cmd;
   hcs_mode_type       fst;
   logic [9:0]         pid_sat;
   logic [32:0]        idle_sum;
   logic [31:0]        idle_sat;
   logic [25:0]        sleep_limit_ms;
   logic               idle_expired;
   logic               watch_run;
   logic [32:0]        watch_sum;
   logic [31:0]        watch_sat;
   logic signed [15:0] cp_use;
   logic signed [16:0] rise;
   logic signed [16:0] min_rise_x;
   logic               runaway;
   logic signed [16:0] step_sum;
   logic               clear;
   logic               fault;

   assign cmd     = hcs_cmd_type'(item.command);
   assign fst     = hcs_mode_type'(item.forced_state);
   assign pid_sat = (item.pid_duty > DUTY_MAX) ? DUTY_MAX : item.pid_duty;

   // saturating timers
   assign idle_sum  = {1'b0, state_cur.idle_ms} + {17'd0, item.tick_ms};
   assign idle_sat  = idle_sum[32] ? '1 : idle_sum[31:0];
   assign watch_sum = {1'b0, state_cur.watch_ms} + {17'd0, item.tick_ms};
   assign watch_sat = watch_sum[32] ? '1 : watch_sum[31:0];

   assign sleep_limit_ms = 26'(cfg.sleep_timeout_s) * 26'(MS_PER_S);
   assign idle_expired   = (cfg.sleep_timeout_s != 16'd0) &&
                           (idle_sat >= {6'd0, sleep_limit_ms});

   assign watch_run  = (pid_sat >= cfg.watch_duty_threshold);
   // take a fresh checkpoint when the window starts
   assign cp_use     = (state_cur.watch_ms == 32'd0) ? item.measured_temp
                                                     : state_cur.checkpoint_temp;
   assign rise       = $signed({item.measured_temp[15], item.measured_temp})
                     - $signed({cp_use[15], cp_use});
   assign min_rise_x = $signed({cfg.watch_min_rise[15], cfg.watch_min_rise});
   assign runaway    = (rise < min_rise_x);

   assign step_sum = $signed({state_cur.target_temp[15], state_cur.target_temp})
                   + $signed({item.value[15], item.value});

   // next state
   always_comb begin
      state_nxt = state_cur;
      clear     = 1'b0;
      fault     = 1'b0;
      unique case (cmd)
         CMD_TICK: begin
            if (state_cur.mode == MODE_OFF || state_cur.mode == MODE_ERROR) begin
               state_nxt.last_duty = '0;
            end else begin
               if (state_cur.mode == MODE_ACTIVE) begin
                  state_nxt.idle_ms = idle_sat;
                  if (idle_expired) begin
                     state_nxt.mode = MODE_SLEEP;
                  end
               end
               state_nxt.last_duty = pid_sat;
               if (watch_run) begin
                  state_nxt.checkpoint_temp = cp_use;
                  state_nxt.watch_ms        = watch_sat;
                  if (watch_sat >= cfg.watch_timeout_ms) begin
                     if (runaway) begin
                        state_nxt.mode = MODE_ERROR;
                        fault          = 1'b1;
                     end else begin
                        state_nxt.watch_ms = '0;
                     end
                  end
               end else begin
                  state_nxt.watch_ms = '0;
               end
               if (state_nxt.mode == MODE_ERROR) begin
                  state_nxt.last_duty = '0;
               end
            end
         end
         CMD_TOGGLE: begin
            if (state_cur.mode == MODE_OFF || state_cur.mode == MODE_SLEEP) begin
               state_nxt.mode     = MODE_ACTIVE;
               state_nxt.watch_ms = '0;
               clear              = 1'b1;
            end else if (state_cur.mode == MODE_ACTIVE) begin
               state_nxt.mode = MODE_OFF;
            end
         end
         CMD_SET: begin
            state_nxt.target_temp = clamp_target($signed({item.value[15], item.value}),
                                                 cfg.min_target, cfg.max_target);
         end
         CMD_STEP: begin
            state_nxt.target_temp = clamp_target(step_sum, cfg.min_target, cfg.max_target);
         end
         CMD_FORCE: begin
            if (fst != state_cur.mode) begin
               state_nxt.mode = fst;
               if (fst == MODE_ACTIVE) begin
                  state_nxt.watch_ms = '0;
                  clear              = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // response beat
   always_comb begin
      result.duty_out      = (state_nxt.mode == MODE_OFF || state_nxt.mode == MODE_ERROR)
                             ? 10'd0 : state_nxt.last_duty;
      result.channel_state = state_nxt.mode;
      result.active_target = (state_nxt.mode == MODE_SLEEP) ? cfg.sleep_target
                                                            : state_nxt.target_temp;
      result.user_target   = state_nxt.target_temp;
      result.pid_clear     = clear;
      result.runaway_fault = fault;
   end

endmodule

`default_nettype wire

// ===== hdl/heater_channel_supervisor.sv =====
// Heater channel supervisor: each beat passes the request register, then the response register.
// Throughput one beat per cycle while the response side is not stalled; the request register and response register
// form a two-stage pipe, and the channel state updates as a beat leaves the first.
// Synchronous active-high reset: channel off, targets and timers zero, registers
// to their defaults, both stages empty.
// Depends on hcs_pkg, hcs_if and hcs_step.
`default_nettype none

module heater_channel_supervisor (
   input  wire logic                              clock,
   input  wire logic                              reset,
   hcs_req_if.sink                                req,
   hcs_rsp_if.source                              rsp,
   input  wire logic                              csr_wr_en,
   input  wire logic [hcs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [hcs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hcs_pkg::*;

   // request stage
   logic          req_valid_ff, req_valid_in;
   hcs_req_type   req_ff;
   // response stage
   logic          rsp_valid_ff, rsp_valid_in;
   hcs_rsp_type   rsp_ff;
   // channel state and configuration
   hcs_state_type state_ff, state_in;
   hcs_cfg_type   cfg_ff, cfg_in;

   hcs_state_type state_step;
   hcs_rsp_type   rsp_step;

   logic          rsp_free;
   logic          step_fire;
   logic          req_fire;

   // the response register can take a beat when empty or draining this cycle
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign step_fire = req_valid_ff && rsp_free;
   assign req.ready = !req_valid_ff || rsp_free;
   assign req_fire  = req.valid && req.ready;

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   hcs_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .item      (req_ff),
      .state_nxt (state_step),
      .result    (rsp_step)
   );

   // advance the pipe; the state commits only when the beat moves on
   always_comb begin
      req_valid_in = req_fire ? 1'b1 : (step_fire ? 1'b0 : req_valid_ff);
      rsp_valid_in = step_fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
      state_in     = step_fire ? state_step : state_ff;
   end

   // register writes; to be issued only while the channel is idle, which the block itself does not enforce
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (hcs_csr_type'(csr_index))
            CSR_MIN_TARGET:     cfg_in.min_target           = csr_wdata[15:0];
            CSR_MAX_TARGET:     cfg_in.max_target           = csr_wdata[15:0];
            CSR_SLEEP_TARGET:   cfg_in.sleep_target         = csr_wdata[15:0];
            CSR_SLEEP_TIMEOUT:  cfg_in.sleep_timeout_s      = csr_wdata[15:0];
            CSR_WATCH_DUTY_THR: cfg_in.watch_duty_threshold = csr_wdata[9:0];
            CSR_WATCH_TIMEOUT:  cfg_in.watch_timeout_ms     = csr_wdata[31:0];
            CSR_WATCH_MIN_RISE: cfg_in.watch_min_rise       = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
         cfg_ff       <= CFG_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers: hold unless a new beat is loaded
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req.payload;
      end
      if (step_fire) begin
         rsp_ff <= rsp_step;
      end
   end

   // a runaway fault always leaves the channel in error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.runaway_fault |-> rsp_ff.channel_state == MODE_ERROR)
      else $error("runaway fault without error state");

   // a PID clear only accompanies entry to active
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.pid_clear |-> rsp_ff.channel_state == MODE_ACTIVE)
      else $error("pid clear outside active state");

   // no drive while off or in error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.channel_state == MODE_OFF ||
                       rsp_ff.channel_state == MODE_ERROR) |-> rsp_ff.duty_out == 10'd0)
      else $error("nonzero duty while off or in error");

   // only a forced state leaves error
   assert property (@(posedge clock) disable iff (reset)
      step_fire && state_ff.mode == MODE_ERROR &&
      req_ff.command != CMD_FORCE |=> state_ff.mode == MODE_ERROR)
      else $error("error state left without a force command");

   // duty never exceeds full scale
   assert property (@(posedge clock) disable iff (reset)
      state_ff.last_duty <= DUTY_MAX)
      else $error("stored duty above full scale");

endmodule

`default_nettype wire
